/* rtl/gbe_pkg.sv */
// gbe_pkg: shared types and constants of the gap buffer editor
// command codes, status codes and the controller/datapath interface structs
// no dependencies
`default_nettype none

package gbe_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned CHR_W = 8;
  localparam int unsigned POS_W = 11;
  localparam int unsigned ST_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_LEFT   = 3'd2;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd3;
  localparam logic [OP_W-1:0] OP_JUMP   = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EDGE  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic            capture;  // latch byte and target of an accepted word
    logic            ins;      // write byte at cursor, advance cursor
    logic            del;      // step cursor back
    logic            rd;       // read the byte that crosses the gap
    logic            wr;       // write it on the other side, move both pointers
    logic            left;     // direction of the byte crossing
    logic            respond;  // register a result
    logic [ST_W-1:0] status;
  } gbe_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic gap_empty;
    logic front_empty;
    logic tail_empty;
    logic tgt_beyond;
    logic tgt_below;
    logic tgt_equal;
    logic tgt_prev;   // target equals cursor minus one
    logic tgt_succ;   // target equals cursor plus one
  } gbe_flags_t;

endpackage

`default_nettype wire

/* rtl/gbe_ctrl.sv */
// gbe_ctrl: command sequencer of the gap buffer editor
// decodes each command word and steps byte crossings; uses gbe_pkg
`default_nettype none

module gbe_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [gbe_pkg::OP_W-1:0] op_i,
  input  wire gbe_pkg::gbe_flags_t      flags_i,
  output gbe_pkg::gbe_cmd_t             cmd_o,
  output logic                          busy_o
);
  import gbe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR
  } state_e;

  state_e          state_q, state_d;
  logic [OP_W-1:0] op_q;
  logic            dir_q, dir_d;
  logic            single_q, single_d;
  logic            last_step;

  assign busy_o    = (state_q != S_IDLE);
  assign last_step = single_q | (dir_q ? flags_i.tgt_prev : flags_i.tgt_succ);

  always_comb begin
    state_d  = state_q;
    dir_d    = dir_q;
    single_d = single_q;
    cmd_o    = '0;
    cmd_o.left   = dir_q;
    cmd_o.status = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d       = S_IDLE;
        cmd_o.respond = 1'b1;
        unique case (op_q)
          OP_INSERT: begin
            if (flags_i.gap_empty) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.ins = 1'b1;
            end
          end
          OP_DELETE: begin
            if (flags_i.front_empty) begin
              cmd_o.status = ST_EDGE;
            end else begin
              cmd_o.del = 1'b1;
            end
          end
          OP_LEFT: begin
            if (flags_i.front_empty) begin
              cmd_o.status = ST_EDGE;
            end else begin
              cmd_o.respond = 1'b0;
              dir_d         = 1'b1;
              single_d      = 1'b1;
              state_d       = S_MOVE_RD;
            end
          end
          OP_RIGHT: begin
            if (flags_i.tail_empty) begin
              cmd_o.status = ST_EDGE;
            end else begin
              cmd_o.respond = 1'b0;
              dir_d         = 1'b0;
              single_d      = 1'b1;
              state_d       = S_MOVE_RD;
            end
          end
          OP_JUMP: begin
            if (flags_i.tgt_beyond) begin
              cmd_o.status = ST_RANGE;
            end else if (!flags_i.tgt_equal) begin
              cmd_o.respond = 1'b0;
              dir_d         = flags_i.tgt_below;
              single_d      = 1'b0;
              state_d       = S_MOVE_RD;
            end
          end
          default: begin
            cmd_o.status = ST_EDGE;
          end
        endcase
      end
      S_MOVE_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.wr = 1'b1;
        if (last_step) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_MOVE_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_INSERT;
      dir_q    <= 1'b0;
      single_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dir_q    <= dir_d;
      single_q <= single_d;
      if (cmd_o.capture) begin
        op_q <= op_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/gbe_datapath.sv */
// gbe_datapath: text store, gap pointers and result registers
// executes commands from gbe_ctrl; uses gbe_pkg
`default_nettype none

module gbe_datapath #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [gbe_pkg::CHR_W-1:0] char_in_i,
  input  wire logic [gbe_pkg::POS_W-1:0] target_i,
  input  wire gbe_pkg::gbe_cmd_t         cmd_i,
  output gbe_pkg::gbe_flags_t            flags_o,
  output logic                           valid_o,
  output logic [gbe_pkg::ST_W-1:0]       status_o,
  output logic [gbe_pkg::POS_W-1:0]      cursor_pos_o,
  output logic [gbe_pkg::POS_W-1:0]      text_length_o
);
  import gbe_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  logic [CHR_W-1:0] mem_q [DEPTH];
  logic [CHR_W-1:0] rdata_q;
  logic [CHR_W-1:0] char_q;
  logic [POS_W-1:0] target_q;
  logic [PW-1:0]    gf_q, gf_d, ts_q, ts_d;
  logic [PW-1:0]    gf_dec, gf_inc, ts_dec, ts_inc;
  logic [PW-1:0]    len_now, len_d, tgt_pw;
  logic [PW-1:0]    wr_pos, rd_pos;
  logic [CHR_W-1:0] wr_data;
  logic             wr_en;
  logic             valid_q;
  logic [ST_W-1:0]  status_q;
  logic [POS_W-1:0] cursor_q, length_q;

  assign gf_dec  = gf_q - 1'b1;
  assign gf_inc  = gf_q + 1'b1;
  assign ts_dec  = ts_q - 1'b1;
  assign ts_inc  = ts_q + 1'b1;
  assign len_now = gf_q + (DEPTH_P - ts_q);
  assign tgt_pw  = PW'(target_q);

  always_comb begin
    gf_d = gf_q;
    ts_d = ts_q;
    if (cmd_i.ins) begin
      gf_d = gf_inc;
    end else if (cmd_i.del) begin
      gf_d = gf_dec;
    end else if (cmd_i.wr) begin
      gf_d = cmd_i.left ? gf_dec : gf_inc;
      ts_d = cmd_i.left ? ts_dec : ts_inc;
    end
  end

  assign len_d = gf_d + (DEPTH_P - ts_d);

  // moving left carries the byte before the cursor to just below the tail
  assign rd_pos  = cmd_i.left ? gf_dec : ts_q;
  assign wr_pos  = (cmd_i.wr && cmd_i.left) ? ts_dec : gf_q;
  assign wr_data = cmd_i.ins ? char_q : rdata_q;
  assign wr_en   = cmd_i.ins | cmd_i.wr;

  always_comb begin
    flags_o.gap_empty   = (gf_q == ts_q);
    flags_o.front_empty = (gf_q == '0);
    flags_o.tail_empty  = (ts_q == DEPTH_P);
    flags_o.tgt_beyond  = (CW'(target_q) > CW'(len_now));
    flags_o.tgt_below   = (tgt_pw < gf_q);
    flags_o.tgt_equal   = (tgt_pw == gf_q);
    flags_o.tgt_prev    = (tgt_pw == gf_dec);
    flags_o.tgt_succ    = (tgt_pw == gf_inc);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_pos[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      char_q   <= char_in_i;
      target_q <= target_i;
    end
    if (cmd_i.respond) begin
      status_q <= cmd_i.status;
      cursor_q <= POS_W'(gf_d);
      length_q <= POS_W'(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gf_q    <= '0;
      ts_q    <= DEPTH_P;
      valid_q <= 1'b0;
    end else begin
      gf_q    <= gf_d;
      ts_q    <= ts_d;
      valid_q <= cmd_i.respond;
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign cursor_pos_o  = cursor_q;
  assign text_length_o = length_q;

endmodule

`default_nettype wire

/* rtl/gap_buffer_editor.sv */
// gap_buffer_editor: top level of the gap buffer byte editor
// joins gbe_ctrl and gbe_datapath; uses gbe_pkg
//
// usage
//   a command word (op_i, char_in_i, target_i) is taken at a rising edge with
//   start_i high and busy_o low. each word yields one result word on status_o,
//   cursor_pos_o and text_length_o, shown for a single cycle with valid_o high.
//   the receiver cannot hold results off; they must be taken when shown.
// timing
//   insert, delete, refused and ignored commands are decided in the decode state,
//   and their result is registered from it.
//   a move is one byte crossing the gap; each crossing is a read step and a
//   write step on the text store, and a jump over n bytes makes n crossings.
//   busy_o is low again in the cycle the result is shown, so the next word may
//   be accepted alongside it.
// reset
//   rst_ni clears the cursor to 0 and the gap to the whole store (empty text).
//   the text store itself is not cleared; no byte is read before it is written.
`default_nettype none

module gap_buffer_editor #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [gbe_pkg::OP_W-1:0]  op_i,
  input  wire logic [gbe_pkg::CHR_W-1:0] char_in_i,
  input  wire logic [gbe_pkg::POS_W-1:0] target_i,
  output logic                           valid_o,
  output logic [gbe_pkg::ST_W-1:0]       status_o,
  output logic [gbe_pkg::POS_W-1:0]      cursor_pos_o,
  output logic [gbe_pkg::POS_W-1:0]      text_length_o
);
  import gbe_pkg::*;

  gbe_cmd_t   cmd;
  gbe_flags_t flags;

  gbe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  gbe_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_in_i     (char_in_i),
    .target_i      (target_i),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .cursor_pos_o  (cursor_pos_o),
    .text_length_o (text_length_o)
  );

`ifndef SYNTHESIS
  // an accepted word keeps the block busy until it has been decoded
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  // every word passes through the decode state, so result words never abut
  a_valid_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result words in consecutive cycles");

  // a byte read across the gap is always written back the next cycle
  a_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |=> cmd.wr)
    else $error("gap crossing read without write");

  // an insert never lands in a full buffer
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |-> !flags.gap_empty)
    else $error("insert into a full buffer");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for the gap buffer editor
// sends edit command words, predicts status, cursor and text length of each one
// and checks every result word; depends on gbe_pkg and gap_buffer_editor

module testbench;
  import gbe_pkg::*;

  localparam int unsigned TEXT_DEPTH   = 1024;
  localparam int unsigned MAX_TARGET   = 1024;
  localparam longint      RUN_LIMIT_NS = 30_000_000;

  // first of the op codes that the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_JUMP + 3'd1;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] length;
  } edit_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [OP_W-1:0]   op_i;
  logic [CHR_W-1:0]  char_in_i;
  logic [POS_W-1:0]  target_i;
  logic              valid_o;
  logic [ST_W-1:0]   status_o;
  logic [POS_W-1:0]  cursor_pos_o;
  logic [POS_W-1:0]  text_length_o;

  // predicted gap pointers: cursor_q is the gap front, tail_q the first byte after it
  int                cursor_q = 0;
  int                tail_q = TEXT_DEPTH;
  edit_result_t      expected_results[$];
  int unsigned       idle_pct = 0;
  int unsigned       error_count = 0;

  gap_buffer_editor #(
    .DEPTH(TEXT_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .char_in_i    (char_in_i),
    .target_i     (target_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .cursor_pos_o (cursor_pos_o),
    .text_length_o(text_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int text_length();
    return cursor_q + (TEXT_DEPTH - tail_q);
  endfunction

  // only the gap pointers show at the outputs, so the byte contents are not tracked
  function automatic edit_result_t apply_edit(logic [OP_W-1:0] op, logic [POS_W-1:0] tgt);
    edit_result_t res;
    logic [ST_W-1:0] st;
    st = ST_EDGE;
    case (op)
      OP_INSERT: begin
        if (cursor_q >= tail_q) begin
          st = ST_FULL;
        end else begin
          cursor_q++;
          st = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (cursor_q > 0) begin
          cursor_q--;
          st = ST_DONE;
        end
      end
      OP_LEFT: begin
        if (cursor_q > 0) begin
          cursor_q--;
          tail_q--;
          st = ST_DONE;
        end
      end
      OP_RIGHT: begin
        if (tail_q < TEXT_DEPTH) begin
          cursor_q++;
          tail_q++;
          st = ST_DONE;
        end
      end
      OP_JUMP: begin
        if (int'(tgt) > text_length()) begin
          st = ST_RANGE;
        end else begin
          // bytes between old and new cursor cross the gap, the gap keeps its size
          tail_q = tail_q + int'(tgt) - cursor_q;
          cursor_q = int'(tgt);
          st = ST_DONE;
        end
      end
      default: st = ST_EDGE;
    endcase
    res.status = st;
    res.cursor = POS_W'(cursor_q);
    res.length = POS_W'(text_length());
    return res;
  endfunction

  // start stays high from word to word unless an idle cycle falls between them
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHR_W-1:0] ch,
                           input logic [POS_W-1:0] tgt);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    op_i      <= op;
    char_in_i <= ch;
    target_i  <= tgt;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_results.push_back(apply_edit(op, tgt));
  endtask

  always @(posedge clk_i) begin : check_result
    edit_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected: status %0d cursor %0d length %0d",
               status_o, cursor_pos_o, text_length_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (cursor_pos_o !== want.cursor) begin
          $error("cursor_pos: expected %0d, got %0d", want.cursor, cursor_pos_o);
          error_count++;
        end
        if (text_length_o !== want.length) begin
          $error("text_length: expected %0d, got %0d", want.length, text_length_o);
          error_count++;
        end
      end
    end
  end

  // commands at the edges of an empty buffer and the unused op codes
  task automatic test_empty_edges();
    idle_pct = 0;
    send_word(OP_DELETE, 8'h00, 11'd0);
    send_word(OP_LEFT, 8'h00, 11'd0);
    send_word(OP_RIGHT, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, 11'd1);
    send_word(OP_JUMP, 8'h00, POS_W'(MAX_TARGET));
    for (int k = 0; k < 3; k++) begin
      send_word(OP_SPARE_FIRST + OP_W'(k), 8'hFF, 11'h3FF);
    end
  endtask

  // short text: single moves, jumps below, above, one off and onto the cursor
  task automatic test_moves_and_jumps();
    idle_pct = 0;
    send_word(OP_INSERT, 8'h00, 11'd0);
    send_word(OP_INSERT, 8'hFF, 11'h7FF);
    send_word(OP_INSERT, 8'hA5, 11'd0);
    send_word(OP_INSERT, 8'h5A, 11'd0);
    send_word(OP_LEFT, 8'h00, 11'd0);
    send_word(OP_LEFT, 8'h00, 11'd0);
    send_word(OP_RIGHT, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, 11'd4);
    send_word(OP_JUMP, 8'h00, 11'd3);
    send_word(OP_JUMP, 8'h00, 11'd4);
    send_word(OP_JUMP, 8'h00, 11'd4);
    send_word(OP_RIGHT, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, 11'd5);
    send_word(OP_DELETE, 8'h00, 11'd0);
  endtask

  // random edits that drift toward longer text; jumps mostly land near the cursor
  task automatic test_random_edits(input int unsigned pct, input int unsigned count);
    int unsigned pick;
    logic [OP_W-1:0] op;
    int tgt;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 32) op = OP_INSERT;
      else if (pick < 48) op = OP_DELETE;
      else if (pick < 62) op = OP_LEFT;
      else if (pick < 76) op = OP_RIGHT;
      else if (pick < 97) op = OP_JUMP;
      else op = OP_SPARE_FIRST + OP_W'($urandom_range(2));
      tgt = $urandom_range(MAX_TARGET);
      if (op == OP_JUMP) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          tgt = cursor_q + int'($urandom_range(8)) - 4;
          if (tgt < 0) tgt = 0;
        end else if (pick < 90) begin
          tgt = $urandom_range(text_length());
        end
      end
      send_word(op, CHR_W'($urandom_range(255)), POS_W'(tgt));
    end
  endtask

  // fill the store completely, then edit and jump across the whole text
  task automatic test_full_buffer();
    idle_pct = 0;
    while (text_length() < TEXT_DEPTH) begin
      send_word(OP_INSERT, CHR_W'($urandom_range(255)), POS_W'($urandom_range(MAX_TARGET)));
    end
    send_word(OP_INSERT, 8'h3C, 11'd0);
    send_word(OP_JUMP, 8'h00, 11'd0);
    send_word(OP_INSERT, 8'hC3, 11'd0);
    send_word(OP_RIGHT, 8'h00, 11'd0);
    send_word(OP_LEFT, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, POS_W'(MAX_TARGET));
    send_word(OP_RIGHT, 8'h00, 11'd0);
    send_word(OP_JUMP, 8'h00, POS_W'(MAX_TARGET));
    send_word(OP_DELETE, 8'h00, 11'd0);
    send_word(OP_INSERT, 8'h81, 11'd0);
    send_word(OP_INSERT, 8'h7E, 11'd0);
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    op_i      <= OP_INSERT;
    char_in_i <= '0;
    target_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_edges();
    test_moves_and_jumps();
    test_random_edits(0, 200);
    test_random_edits(62, 200);
    test_random_edits(7, 200);
    test_full_buffer();
    start_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench: errors");
    $finish;
  end

endmodule
